### hw/rtl/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// Used by the top module bitmap_slot_allocator; depends on nothing.
package bsa_pkg;

   localparam int MAX_SLOTS_DEFAULT = 1024;
   localparam int WORD_BITS_MAX     = 32;
   localparam int CSR_BITS          = 11;
   localparam int SLOT_SPAN         = 1 << CSR_BITS;

   localparam logic [CSR_BITS-1:0] NUM_SLOTS_RESET = 11'd1024;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_INIT  = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [9:0] slot_in;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [9:0]  slot_out;
      logic [10:0] free_count;
   } rsp_type;

endpackage

### hw/rtl/bsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int ADDR_BITS = 5
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bsa_scan.sv
// Bitmap word scanner: masks each returned word to the active slot range,
// accumulates the free count and keeps the first free word and the target word.
module bsa_scan #(
   parameter int WORD_BITS = 32,
   parameter int ADDR_BITS = 5,
   parameter int CMP_BITS = 18
) (
   input  logic                         clock,
   input  logic                         start,
   input  logic                         rd_valid,
   input  logic [ADDR_BITS-1:0]         rd_addr,
   input  logic [WORD_BITS-1:0]         rd_data,
   input  logic [10:0]                  limit,
   input  logic [ADDR_BITS-1:0]         tgt_addr,
   output logic [10:0]                  count_ff,
   output logic                         found_ff,
   output logic [ADDR_BITS-1:0]         found_addr_ff,
   output logic [$clog2(WORD_BITS)-1:0] found_bit_ff,
   output logic [WORD_BITS-1:0]         found_data_ff,
   output logic [WORD_BITS-1:0]         tgt_data_ff
);

   localparam int WB = $clog2(WORD_BITS);

   logic [CMP_BITS-1:0]  base;
   logic [CMP_BITS-1:0]  rem;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] masked;
   logic [WB:0]          pop;
   logic [WB-1:0]        low_bit;
   logic                 hit;

   always_comb begin
      base = CMP_BITS'({rd_addr, {WB{1'b0}}});
      rem = CMP_BITS'(limit) - base;
      for (int j = 0; j < WORD_BITS; j++) begin
         mask[j] = CMP_BITS'(j) < rem;
      end
      masked = rd_data & mask;
      hit = |masked;
      pop = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         pop = pop + (WB+1)'(masked[j]);
      end
      low_bit = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (masked[j]) begin
            low_bit = WB'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         count_ff <= '0;
         found_ff <= 1'b0;
      end else if (rd_valid) begin
         count_ff <= count_ff + 11'(pop);
         if (!found_ff && hit) begin
            found_ff      <= 1'b1;
            found_addr_ff <= rd_addr;
            found_bit_ff  <= low_bit;
            found_data_ff <= rd_data;
         end
         if (rd_addr == tgt_addr) begin
            tgt_data_ff <= rd_data;
         end
      end
   end

endmodule

### hw/rtl/bitmap_slot_allocator.sv
// Bitmap slot allocator, free bitmap held in one word-wide RAM (32 slots a word).
// Allocate, free and unknown requests read ceil(n/32) words, n the active slot count
// (none with no active slot); init writes MAX_SLOTS/32 words (at most 64). One item
// at a time; the next item is taken while a result waits. Reset: synchronous; a fill
// sweep of the same word count marks every slot free, req_stall high until done.
module bitmap_slot_allocator import bsa_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_write_enable,
   input  logic [CSR_BITS-1:0] csr_write_data
);

   localparam int W = (MAX_SLOTS < WORD_BITS_MAX) ? MAX_SLOTS : WORD_BITS_MAX;
   localparam int WB = $clog2(W);
   localparam int DEPTH = MAX_SLOTS / W;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SWEEP_WORDS = (DEPTH < SLOT_SPAN / W) ? DEPTH : SLOT_SPAN / W;
   localparam int CMP_BITS = ((AW + WB + 1 > CSR_BITS) ? AW + WB + 1 : CSR_BITS) + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [AW-1:0] SWEEP_LAST = AW'(SWEEP_WORDS - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_SWEEP  = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [10:0]         limit_ff, limit_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic                issue_ff, issue_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [AW-1:0]       rd_addr_ff;
   logic                rd_last_ff;
   logic                report_ff, report_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CSR_BITS-1:0] num_slots_ff;

   logic                accept;
   logic [10:0]         limit_new;
   logic [CMP_BITS-1:0] next_base;
   logic                issue_last;
   logic [CMP_BITS-1:0] slot_ext;
   logic [CMP_BITS-1:0] tgt_full;
   logic [AW-1:0]       tgt_addr;
   logic [WB-1:0]       tgt_bit;
   logic                in_range;
   logic [AW+WB+9:0]    grant_ext;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [W-1:0]        wr_data;
   logic                ram_rd_en;
   logic [W-1:0]        rd_data;

   logic [10:0]         count;
   logic                found;
   logic [AW-1:0]       found_addr;
   logic [WB-1:0]       found_bit;
   logic [W-1:0]        found_data;
   logic [W-1:0]        tgt_data;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign limit_new = (CMP_BITS'(num_slots_ff) > CMP_BITS'(MAX_SLOTS)) ?
                      11'(MAX_SLOTS) : num_slots_ff;
   assign next_base = CMP_BITS'({1'b0, addr_ff} + (AW+1)'(1)) << WB;
   assign issue_last = (next_base >= CMP_BITS'(limit_ff)) || (addr_ff == LAST_ADDR);
   assign slot_ext = CMP_BITS'(req_ff.slot_in);
   assign tgt_full = slot_ext >> WB;
   assign tgt_addr = tgt_full[AW-1:0];
   assign tgt_bit = req_ff.slot_in[WB-1:0];
   assign in_range = {1'b0, req_ff.slot_in} < limit_ff;
   assign grant_ext = (AW+WB+10)'({found_addr, found_bit});
   assign ram_rd_en = (state_ff == ST_SCAN) && issue_ff;

   bsa_ram #(
      .WIDTH(W),
      .DEPTH(DEPTH),
      .ADDR_BITS(AW)
   ) u_map (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   bsa_scan #(
      .WORD_BITS(W),
      .ADDR_BITS(AW),
      .CMP_BITS(CMP_BITS)
   ) u_scan (
      .clock(clock),
      .start(accept),
      .rd_valid(rd_valid_ff),
      .rd_addr(rd_addr_ff),
      .rd_data(rd_data),
      .limit(limit_ff),
      .tgt_addr(tgt_addr),
      .count_ff(count),
      .found_ff(found),
      .found_addr_ff(found_addr),
      .found_bit_ff(found_bit),
      .found_data_ff(found_data),
      .tgt_data_ff(tgt_data)
   );

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      limit_in = limit_ff;
      addr_in = addr_ff;
      issue_in = issue_ff;
      report_in = report_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_valid_in = 1'b0;
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = '1;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               limit_in = limit_new;
               addr_in = '0;
               if (req_data.cmd == CMD_INIT) begin
                  report_in = 1'b1;
                  state_in = ST_SWEEP;
               end else if (limit_new == '0) begin
                  res_in = '0;
                  state_in = ST_DONE;
               end else begin
                  issue_in = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_valid_in = issue_ff;
            if (issue_ff) begin
               if (issue_last) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + AW'(1);
               end
            end
            if (rd_valid_ff && rd_last_ff) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            res_in.ok = 1'b0;
            res_in.slot_out = '0;
            res_in.free_count = count;
            case (req_ff.cmd)
               CMD_ALLOC: begin
                  if (found) begin
                     wr_en = 1'b1;
                     wr_addr = found_addr;
                     wr_data = found_data & ~(W'(1) << found_bit);
                     res_in.ok = 1'b1;
                     res_in.slot_out = grant_ext[9:0];
                     res_in.free_count = count - 11'd1;
                  end
               end
               CMD_FREE: begin
                  if (in_range && !tgt_data[tgt_bit]) begin
                     wr_en = 1'b1;
                     wr_addr = tgt_addr;
                     wr_data = tgt_data | (W'(1) << tgt_bit);
                     res_in.ok = 1'b1;
                     res_in.free_count = count + 11'd1;
                  end
               end
               default: begin
               end
            endcase
            state_in = ST_DONE;
         end
         ST_SWEEP: begin
            wr_en = 1'b1;
            if (addr_ff == SWEEP_LAST) begin
               res_in.ok = 1'b1;
               res_in.slot_out = '0;
               res_in.free_count = limit_ff;
               state_in = report_ff ? ST_DONE : ST_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         addr_ff <= '0;
         issue_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
         report_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         num_slots_ff <= NUM_SLOTS_RESET;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         issue_ff <= issue_in;
         rd_valid_ff <= rd_valid_in;
         report_ff <= report_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            num_slots_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      limit_ff <= limit_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      rd_addr_ff <= addr_ff;
      rd_last_ff <= issue_last;
   end

endmodule
